[rtl/core/text_console_cursor_engine_assert.svh]
// Assertion macros for the text console cursor engine.
// Used by the top level; no other dependencies.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
// clocked check, switched off while reset is high
`define TCC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tcc assertion failed");
// clocked check that also holds through reset
`define TCC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tcc assertion failed");
`else
`define TCC_ASSERT(lbl, clk, rst, prop)
`define TCC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[rtl/core/tcc_pkg.sv]
// Shared types and constants for the text console cursor engine.
// No dependencies.
package tcc_pkg;

  localparam int ADDR_W    = 3;
  localparam int CNT_W     = 4;
  localparam int ALU_W     = 10;
  localparam int MAX_DRAWS = 8;

  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  // register index, taken from paddr[2]
  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_ROWS    = 1'b1;

  localparam logic [8:0] COLUMNS_RST = 9'd80;
  localparam logic [8:0] ROWS_RST    = 9'd25;

  typedef struct packed {
    logic [7:0]  char_code;
    logic [31:0] fore_color;
    logic [31:0] back_color;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  cell_col;
    logic [7:0]  cell_row;
    logic [7:0]  glyph_code;
    logic [31:0] draw_fore;
    logic [31:0] draw_back;
    logic        last;
  } out_item_t;

  // effective grid size, 1..256
  typedef struct packed {
    logic [8:0] ncol;
    logic [8:0] nrow;
  } grid_t;

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic [ALU_W-1:0] lim;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] sum;
    logic             ge;
  } alu_rsp_t;

  // zero acts as 1, anything above 256 as 256
  function automatic logic [8:0] eff_size(input logic [8:0] v);
    logic [8:0] r;
    r = v;
    if (v == 9'd0) r = 9'd1;
    else if (v > 9'd256) r = 9'd256;
    return r;
  endfunction

endpackage

[rtl/core/tcc_stream_if.sv]
// Valid/ready stream channel carrying one payload struct.
// Payload type is set at instantiation (see tcc_pkg).
interface tcc_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/tcc_alu.sv]
// Shared add-and-compare unit: sum = a + b, ge = (sum >= lim).
// Depends on tcc_pkg.
module tcc_alu (
  input  tcc_pkg::alu_req_t req,
  output tcc_pkg::alu_rsp_t rsp
);
  logic [tcc_pkg::ALU_W-1:0] sum;

  assign sum     = req.a + req.b;
  assign rsp.sum = sum;
  assign rsp.ge  = (sum >= req.lim);
endmodule

[rtl/core/tcc_cfg.sv]
// APB-style register file holding columns and rows, plus effective sizes.
// Depends on tcc_pkg.
module tcc_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tcc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output tcc_pkg::grid_t             grid
);
  logic [8:0] columns;
  logic [8:0] rows;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      columns <= tcc_pkg::COLUMNS_RST;
      rows    <= tcc_pkg::ROWS_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        tcc_pkg::REG_COLUMNS: columns <= pwdata[8:0];
        tcc_pkg::REG_ROWS:    rows    <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      tcc_pkg::REG_COLUMNS: prdata = {23'd0, columns};
      tcc_pkg::REG_ROWS:    prdata = {23'd0, rows};
      default:              prdata = 32'd0;
    endcase
  end

  assign grid.ncol = tcc_pkg::eff_size(columns);
  assign grid.nrow = tcc_pkg::eff_size(rows);
endmodule

[rtl/core/tcc_seq.sv]
// Sequencer: cursor state, tab remainder, draw loop and output register.
// Depends on tcc_pkg and tcc_stream_if; drives the shared tcc_alu.
module tcc_seq #(
  parameter int TAB_WIDTH = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  tcc_pkg::grid_t    grid,
  tcc_stream_if.sink        in_ch,
  tcc_stream_if.source      out_ch,
  output tcc_pkg::alu_req_t alu_req,
  input  tcc_pkg::alu_rsp_t alu_rsp
);
  localparam int REM_W = $clog2(TAB_WIDTH);
  localparam int AW    = tcc_pkg::ALU_W;
  localparam logic [AW-1:0] TAB_C   = AW'(TAB_WIDTH);
  localparam logic [AW-1:0] MINUS1  = '1;
  localparam logic [AW-1:0] CAP_LIM = AW'(tcc_pkg::MAX_DRAWS + 1);
  // column / TAB_WIDTH as (column * RCP_M) >> RCP_SH, exact for any 8-bit column
  localparam int RCP_SH = 8 + REM_W;
  localparam int RCP_M  = ((1 << RCP_SH) + TAB_WIDTH - 1) / TAB_WIDTH;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_NL     = 4'd1;
  localparam logic [3:0] S_BS_COL = 4'd2;
  localparam logic [3:0] S_BS_ROW = 4'd3;
  localparam logic [3:0] S_REM    = 4'd4;
  localparam logic [3:0] S_TCNT   = 4'd5;
  localparam logic [3:0] S_EMIT   = 4'd6;
  localparam logic [3:0] S_COL    = 4'd7;
  localparam logic [3:0] S_ROW    = 4'd8;

  logic [3:0]              state;
  logic [7:0]              col;
  logic [7:0]              row;
  logic [tcc_pkg::CNT_W-1:0] cnt;
  logic [REM_W-1:0]        rem;
  logic [17:0]             rcp_prod;
  logic [7:0]              quot;
  logic [7:0]              quot_d;
  logic [7:0]              rem_full;
  logic                    inc;
  logic                    carry;
  logic                    bs_colz;
  logic                    bs_rowz;
  logic [7:0]              glyph;
  logic [31:0]             fg;
  logic [31:0]             bg;
  logic                    out_valid;
  tcc_pkg::out_item_t      out_item;
  logic                    in_fire;
  logic                    out_free;
  logic [7:0]              ch;

  assign in_ch.ready    = (state == S_IDLE);
  assign in_fire        = in_ch.valid && in_ch.ready;
  assign ch             = in_ch.payload.char_code;
  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_item;
  assign out_free       = !out_valid || out_ch.ready;

  // column modulo TAB_WIDTH by reciprocal multiply
  assign rcp_prod = 18'(col) * 18'(RCP_M);
  assign quot     = 8'(rcp_prod >> RCP_SH);
  assign quot_d   = 8'(16'(quot) * 16'(TAB_WIDTH));
  assign rem_full = col - quot_d;

  // operand select for the shared unit
  always_comb begin
    alu_req.a   = AW'(col);
    alu_req.b   = '0;
    alu_req.lim = AW'(grid.ncol);
    unique case (state)
      S_NL: begin
        alu_req.a   = AW'(row);
        alu_req.b   = AW'(1);
        alu_req.lim = AW'(grid.nrow);
      end
      S_BS_COL: begin
        alu_req.a = bs_colz ? AW'(grid.ncol) : AW'(col);
        alu_req.b = MINUS1;
      end
      S_BS_ROW: begin
        alu_req.a = bs_rowz ? AW'(grid.nrow) : AW'(row);
        alu_req.b = MINUS1;
      end
      S_TCNT: begin
        alu_req.a   = TAB_C;
        alu_req.b   = AW'(0) - AW'(rem);
        alu_req.lim = CAP_LIM;
      end
      S_COL: begin
        alu_req.a = AW'(col);
        alu_req.b = AW'(inc);
      end
      S_ROW: begin
        alu_req.a   = AW'(row);
        alu_req.b   = AW'(carry);
        alu_req.lim = AW'(grid.nrow);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      col       <= '0;
      row       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_EMIT && out_free) out_valid <= 1'b1;
      else if (out_ch.ready)           out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            fg      <= in_ch.payload.fore_color;
            bg      <= in_ch.payload.back_color;
            cnt     <= tcc_pkg::CNT_W'(1);
            bs_colz <= (col == 8'd0);
            bs_rowz <= (row == 8'd0);
            if (ch == tcc_pkg::CH_NEWLINE) begin
              glyph <= ch;
              inc   <= 1'b1;
              state <= S_NL;
            end else if (ch == tcc_pkg::CH_BACKSPACE) begin
              glyph <= tcc_pkg::CH_SPACE;
              inc   <= 1'b0;
              state <= S_BS_COL;
            end else if (ch == tcc_pkg::CH_TAB) begin
              glyph <= tcc_pkg::CH_SPACE;
              inc   <= 1'b1;
              state <= S_REM;
            end else begin
              glyph <= ch;
              inc   <= 1'b1;
              state <= S_EMIT;
            end
          end
        end
        S_NL: begin
          col   <= '0;
          row   <= alu_rsp.ge ? 8'd0 : alu_rsp.sum[7:0];
          state <= S_IDLE;
        end
        S_BS_COL: begin
          col   <= alu_rsp.sum[7:0];
          state <= bs_colz ? S_BS_ROW : S_EMIT;
        end
        S_BS_ROW: begin
          row   <= alu_rsp.sum[7:0];
          state <= S_EMIT;
        end
        S_REM: begin
          // distance into the current tab stop
          rem   <= rem_full[REM_W-1:0];
          state <= S_TCNT;
        end
        S_TCNT: begin
          cnt   <= alu_rsp.ge ? tcc_pkg::CNT_W'(tcc_pkg::MAX_DRAWS)
                              : alu_rsp.sum[tcc_pkg::CNT_W-1:0];
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_item.cell_col   <= col;
            out_item.cell_row   <= row;
            out_item.glyph_code <= glyph;
            out_item.draw_fore  <= fg;
            out_item.draw_back  <= bg;
            out_item.last       <= (cnt == tcc_pkg::CNT_W'(1));
            cnt                 <= cnt - tcc_pkg::CNT_W'(1);
            state               <= S_COL;
          end
        end
        S_COL: begin
          if (alu_rsp.ge) begin
            col   <= '0;
            carry <= 1'b1;
          end else begin
            col   <= alu_rsp.sum[7:0];
            carry <= 1'b0;
          end
          state <= S_ROW;
        end
        S_ROW: begin
          row   <= alu_rsp.ge ? 8'd0 : alu_rsp.sum[7:0];
          state <= (cnt != '0) ? S_EMIT : S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[rtl/core/text_console_cursor_engine.sv]
// Top level of the text console cursor engine: register port, sequencer, shared unit.
// Depends on tcc_pkg, tcc_stream_if, tcc_alu, tcc_cfg, tcc_seq and the assertion header.
//
//  channel  dir  payload                                               handshake
//  in_ch    in   char_code, fore_color, back_color                     valid/ready
//  out_ch   out  cell_col, cell_row, glyph_code, draw_fore/back, last  valid/ready
//  apb      in   columns (0x0), rows (0x4)                             psel/penable
//
// Steps per byte, all but remainder and emit on the single add-and-compare unit:
//   newline a row step; ordinary glyph emit, column, row; backspace column (and row
//   from column 0) back, then glyph steps; tab remainder, count, glyph steps per space.
// in_ch.ready is high only when the sequencer is idle. A finished draw sits in the
// output register; the sequencer stalls in its emit step only while that register
// is still full and out_ch.ready is low.
// Reset (rst, synchronous) puts the cursor at 0,0 and the grid at 80 x 25.
`include "text_console_cursor_engine_assert.svh"

module text_console_cursor_engine #(
  parameter int TAB_WIDTH = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tcc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // character stream in, draw commands out
  tcc_stream_if.sink                 in_ch,
  tcc_stream_if.source               out_ch
);
  tcc_pkg::grid_t    grid;
  tcc_pkg::alu_req_t alu_req;
  tcc_pkg::alu_rsp_t alu_rsp;

  // register file; yields the clamped grid size
  tcc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .grid    (grid)
  );

  // cursor sequencer; owns the output register
  tcc_seq #(
    .TAB_WIDTH (TAB_WIDTH)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .grid    (grid),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .alu_req (alu_req),
    .alu_rsp (alu_rsp)
  );

  // the one adder/comparator, time-shared by all but the remainder and emit steps
  tcc_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  logic in_fire;
  logic nl_fire;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign nl_fire = in_fire && (in_ch.payload.char_code == tcc_pkg::CH_NEWLINE);

  // newline: busy for the row step, then ready again
  `TCC_ASSERT(a_nl_two_cycles, clk, rst, nl_fire |=> (!in_ch.ready ##1 in_ch.ready))
  // once ready for a new byte, any draw still waiting must close the previous byte
  `TCC_ASSERT(a_idle_pending_last, clk, rst, (in_ch.ready && out_ch.valid) |-> out_ch.payload.last)
  // reset empties the output register
  `TCC_ASSERT_ALWAYS(a_rst_empties_out, clk, rst |=> !out_ch.valid)
endmodule
